FILE: hdl/lsgc_pkg.sv
// package: types, register codes and constants of the laser scan gap clustering block
`default_nettype none
package lsgc_pkg;

    localparam int MAX_POINTS_DEF = 4096;
    localparam int CNT_W          = 13;
    localparam int CFG_IDX_W      = 4;
    localparam logic [CNT_W-1:0] LABEL_MAX = 13'd8191;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SENSOR_X   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SENSOR_Y   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SENSOR_Z   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NEAR_GAP   = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FAR_RANGE  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_SLOPE  = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_EXTENT = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_AREA   = 4'd7;

    // reset values
    localparam logic [15:0] NEAR_GAP_RST   = 16'd500;
    localparam logic [19:0] FAR_RANGE_RST  = 20'd23000;
    localparam logic [15:0] GAP_SLOPE_RST  = 16'd572;
    localparam logic [7:0]  MAX_EXTENT_RST = 8'd15;
    localparam logic [15:0] MAX_AREA_RST   = 16'd200;

    typedef struct packed {
        logic signed [15:0] cell_x;
        logic signed [15:0] cell_y;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic               first_point;
        logic               last_point;
    } in_item_t;

    typedef struct packed {
        logic [CNT_W-1:0]   cluster_label;
        logic [CNT_W-1:0]   point_count;
        logic [7:0]         extent_x;
        logic [7:0]         extent_y;
        logic signed [31:0] mean_x;
        logic signed [31:0] mean_y;
        logic signed [31:0] mean_z;
        logic               last_of_run;
    } out_item_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [31:0]          data;
    } cfg_req_t;

endpackage
`default_nettype wire

FILE: hdl/lsgc_if.sv
// interfaces: point input, cluster output and register write channels
`default_nettype none
interface lsgc_in_if;
    import lsgc_pkg::*;
    logic     valid;
    logic     ready;
    in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface lsgc_out_if;
    import lsgc_pkg::*;
    logic      valid;
    logic      ready;
    out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface lsgc_cfg_if;
    import lsgc_pkg::*;
    logic     valid;
    logic     ready;
    cfg_req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hdl/laser_scan_gap_clustering.sv
// top level: laser scan gap clustering with a shared multiplier and a serial divider
// sequencing: a point that opens or joins a cluster keeps the sequencer busy (the join test
//   takes 12 steps over 9 products); a close checks extents and area, then derives means
// throughput: one point at a time; ready is high only while the sequencer is idle
// a finished result waits in the output register while the next point is taken
// reset: rst_n asynchronous active low, clears state and loads register defaults
`default_nettype none
module laser_scan_gap_clustering #(
    parameter int MAX_POINTS = lsgc_pkg::MAX_POINTS_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    lsgc_in_if.sink     in_ch,
    lsgc_out_if.source  out_ch,
    lsgc_cfg_if.sink    cfg_ch
);
    import lsgc_pkg::*;

    // count cap and sum width follow from the point limit
    localparam int CAP_I  = (MAX_POINTS < 8191) ? MAX_POINTS : 8191;
    localparam logic [CNT_W-1:0] CAP = CNT_W'(CAP_I);
    localparam int SUM_W  = 33 + $clog2(CAP_I);
    localparam int DCNT_W = $clog2(SUM_W + 1);

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH,
        S_J_DX, S_J_DY, S_J_SX, S_J_SY, S_J_FAR, S_J_NEAR, S_J_K, S_J_KW,
        S_J_PLO, S_J_PMID, S_J_ACC, S_J_DEC,
        S_LASTCHK, S_C_EXT, S_C_CHK, S_DIV_LD, S_DIV_RUN, S_DIV_ST, S_EMIT, S_C_DONE
    } state_t;

    function automatic logic [31:0] abs_diff(input logic signed [31:0] a,
                                             input logic signed [31:0] b);
        logic signed [32:0] d;
        d = 33'(a) - 33'(b);
        return d[32] ? 32'(-d) : d[31:0];
    endfunction

    state_t state_reg;

    // configuration registers
    logic signed [31:0] sensor_x_reg, sensor_y_reg, sensor_z_reg;
    logic [15:0] near_gap_reg, gap_slope_reg, max_area_reg;
    logic [19:0] far_range_reg;
    logic [7:0]  max_extent_reg;

    // cluster state
    logic [CNT_W-1:0]   label_reg, count_reg;
    logic signed [15:0] min_x_reg, max_x_reg, min_y_reg, max_y_reg;
    logic signed [SUM_W-1:0] sum_x_reg, sum_y_reg, sum_z_reg;
    logic signed [31:0] prev_x_reg, prev_y_reg;
    in_item_t           item_reg;

    // join test datapath
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_reg;
    logic [64:0] gap_reg, d2_reg;
    logic [39:0] far2_reg;
    logic [31:0] near2_reg, k_reg;
    logic [96:0] acc_reg;

    // close datapath
    logic [16:0] ex_c, ey_c, ex_reg, ey_reg;
    logic        phase_last_reg;   // current close is the one caused by last_point
    logic [1:0]  coord_reg;
    logic [SUM_W-1:0] div_q_reg;
    logic [CNT_W-1:0] div_r_reg;
    logic [DCNT_W-1:0] div_cnt_reg;
    logic        div_neg_reg;
    logic signed [31:0] mean_x_reg, mean_y_reg, mean_z_reg;

    logic        out_valid_reg;
    out_item_t   out_reg;

    logic        pose_known, far_case, joins, single_pass, close_fail;
    logic signed [SUM_W-1:0] sum_sel;
    logic [CNT_W:0]   rem_t;
    logic             rem_ge;
    logic [SUM_W-1:0] q_signed;

    assign in_ch.ready  = (state_reg == S_IDLE);
    assign cfg_ch.ready = 1'b1;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_reg;

    assign pose_known = (sensor_x_reg != '0) || (sensor_y_reg != '0) || (sensor_z_reg != '0);
    assign far_case   = pose_known && (d2_reg >= {25'd0, far2_reg});
    assign joins      = far_case ? ({gap_reg, 32'd0} < acc_reg)
                                 : (gap_reg < {33'd0, near2_reg});
    // a fresh one-point cluster passes when both limits exceed one
    assign single_pass = (max_extent_reg > 8'd1) && (max_area_reg > 16'd1);

    assign ex_c = 17'({max_x_reg[15], max_x_reg} - {min_x_reg[15], min_x_reg}) + 17'd1;
    assign ey_c = 17'({max_y_reg[15], max_y_reg} - {min_y_reg[15], min_y_reg}) + 17'd1;
    assign close_fail = (ex_reg >= {9'd0, max_extent_reg}) ||
                        (ey_reg >= {9'd0, max_extent_reg}) ||
                        (mul_reg[33:0] >= {18'd0, max_area_reg});

    always_comb
    begin
        case (coord_reg)
            2'd0:    sum_sel = sum_x_reg;
            2'd1:    sum_sel = sum_y_reg;
            default: sum_sel = sum_z_reg;
        endcase
    end

    // restoring divider step
    assign rem_t    = {div_r_reg, div_q_reg[SUM_W-1]};
    assign rem_ge   = rem_t >= {1'b0, count_reg};
    assign q_signed = div_neg_reg ? (~div_q_reg + 1'b1) : div_q_reg;

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_J_DX:
            begin
                mul_a = abs_diff(item_reg.pos_x, prev_x_reg);
                mul_b = mul_a;
            end
            S_J_DY:
            begin
                mul_a = abs_diff(item_reg.pos_y, prev_y_reg);
                mul_b = mul_a;
            end
            S_J_SX:
            begin
                mul_a = abs_diff(item_reg.pos_x, sensor_x_reg);
                mul_b = mul_a;
            end
            S_J_SY:
            begin
                mul_a = abs_diff(item_reg.pos_y, sensor_y_reg);
                mul_b = mul_a;
            end
            S_J_FAR:
            begin
                mul_a = {12'd0, far_range_reg};
                mul_b = mul_a;
            end
            S_J_NEAR:
            begin
                mul_a = {16'd0, near_gap_reg};
                mul_b = mul_a;
            end
            S_J_K:
            begin
                mul_a = {16'd0, gap_slope_reg};
                mul_b = mul_a;
            end
            S_J_PLO:
            begin
                mul_a = d2_reg[31:0];
                mul_b = k_reg;
            end
            S_J_PMID:
            begin
                mul_a = d2_reg[63:32];
                mul_b = k_reg;
            end
            S_C_EXT:
            begin
                mul_a = {15'd0, ex_c};
                mul_b = {15'd0, ey_c};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            sensor_x_reg   <= '0;
            sensor_y_reg   <= '0;
            sensor_z_reg   <= '0;
            near_gap_reg   <= NEAR_GAP_RST;
            far_range_reg  <= FAR_RANGE_RST;
            gap_slope_reg  <= GAP_SLOPE_RST;
            max_extent_reg <= MAX_EXTENT_RST;
            max_area_reg   <= MAX_AREA_RST;
            label_reg      <= '0;
            count_reg      <= '0;
            min_x_reg      <= '0;
            max_x_reg      <= '0;
            min_y_reg      <= '0;
            max_y_reg      <= '0;
            sum_x_reg      <= '0;
            sum_y_reg      <= '0;
            sum_z_reg      <= '0;
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
            phase_last_reg <= 1'b0;
            coord_reg      <= '0;
            div_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            mul_reg <= 64'(mul_a) * 64'(mul_b);

            // the emit step refills the output register itself
            if (out_valid_reg && out_ch.ready && state_reg != S_EMIT)
                out_valid_reg <= 1'b0;

            // register write request
            if (cfg_ch.valid)
            begin
                case (cfg_ch.data.index)
                    REG_SENSOR_X:   sensor_x_reg   <= cfg_ch.data.data;
                    REG_SENSOR_Y:   sensor_y_reg   <= cfg_ch.data.data;
                    REG_SENSOR_Z:   sensor_z_reg   <= cfg_ch.data.data;
                    REG_NEAR_GAP:   near_gap_reg   <= cfg_ch.data.data[15:0];
                    REG_FAR_RANGE:  far_range_reg  <= cfg_ch.data.data[19:0];
                    REG_GAP_SLOPE:  gap_slope_reg  <= cfg_ch.data.data[15:0];
                    REG_MAX_EXTENT: max_extent_reg <= cfg_ch.data.data[7:0];
                    REG_MAX_AREA:   max_area_reg   <= cfg_ch.data.data[15:0];
                    default:        ;
                endcase
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_ch.valid)
                    begin
                        item_reg  <= in_ch.data;
                        state_reg <= S_DISPATCH;
                    end
                end
                S_DISPATCH:
                begin
                    if (item_reg.first_point || count_reg == '0)
                    begin
                        // new scan restarts labels, otherwise labels run on
                        if (item_reg.first_point)
                            label_reg <= CNT_W'(1);
                        else if (label_reg < LABEL_MAX)
                            label_reg <= label_reg + 1'b1;
                        count_reg  <= CNT_W'(1);
                        min_x_reg  <= item_reg.cell_x;
                        max_x_reg  <= item_reg.cell_x;
                        min_y_reg  <= item_reg.cell_y;
                        max_y_reg  <= item_reg.cell_y;
                        sum_x_reg  <= SUM_W'(item_reg.pos_x);
                        sum_y_reg  <= SUM_W'(item_reg.pos_y);
                        sum_z_reg  <= SUM_W'(item_reg.pos_z);
                        prev_x_reg <= item_reg.pos_x;
                        prev_y_reg <= item_reg.pos_y;
                        state_reg  <= S_LASTCHK;
                    end
                    else
                        state_reg <= S_J_DX;
                end
                // squared gap to the previous point
                S_J_DX:  state_reg <= S_J_DY;
                S_J_DY:
                begin
                    gap_reg   <= {1'b0, mul_reg};
                    state_reg <= S_J_SX;
                end
                S_J_SX:
                begin
                    gap_reg   <= gap_reg + {1'b0, mul_reg};
                    state_reg <= S_J_SY;
                end
                // squared range to the sensor
                S_J_SY:
                begin
                    d2_reg    <= {1'b0, mul_reg};
                    state_reg <= S_J_FAR;
                end
                S_J_FAR:
                begin
                    d2_reg    <= d2_reg + {1'b0, mul_reg};
                    state_reg <= S_J_NEAR;
                end
                S_J_NEAR:
                begin
                    far2_reg  <= mul_reg[39:0];
                    state_reg <= S_J_K;
                end
                S_J_K:
                begin
                    near2_reg <= mul_reg[31:0];
                    state_reg <= S_J_KW;
                end
                S_J_KW:
                begin
                    k_reg     <= mul_reg[31:0];
                    state_reg <= S_J_PLO;
                end
                // range squared times slope squared, in 32-bit pieces
                S_J_PLO: state_reg <= S_J_PMID;
                S_J_PMID:
                begin
                    acc_reg   <= {33'd0, mul_reg} +
                                 (d2_reg[64] ? {k_reg, 64'd0} : 97'd0);
                    state_reg <= S_J_ACC;
                end
                S_J_ACC:
                begin
                    acc_reg   <= acc_reg + {1'b0, mul_reg, 32'd0};
                    state_reg <= S_J_DEC;
                end
                S_J_DEC:
                begin
                    if (joins)
                    begin
                        if (item_reg.cell_x < min_x_reg) min_x_reg <= item_reg.cell_x;
                        if (item_reg.cell_x > max_x_reg) max_x_reg <= item_reg.cell_x;
                        if (item_reg.cell_y < min_y_reg) min_y_reg <= item_reg.cell_y;
                        if (item_reg.cell_y > max_y_reg) max_y_reg <= item_reg.cell_y;
                        // past the cap points shape the extents and the previous point only
                        if (count_reg < CAP)
                        begin
                            count_reg <= count_reg + 1'b1;
                            sum_x_reg <= sum_x_reg + SUM_W'(item_reg.pos_x);
                            sum_y_reg <= sum_y_reg + SUM_W'(item_reg.pos_y);
                            sum_z_reg <= sum_z_reg + SUM_W'(item_reg.pos_z);
                        end
                        prev_x_reg <= item_reg.pos_x;
                        prev_y_reg <= item_reg.pos_y;
                        state_reg  <= S_LASTCHK;
                    end
                    else
                    begin
                        phase_last_reg <= 1'b0;
                        state_reg      <= S_C_EXT;
                    end
                end
                S_LASTCHK:
                begin
                    if (item_reg.last_point)
                    begin
                        phase_last_reg <= 1'b1;
                        state_reg      <= S_C_EXT;
                    end
                    else
                        state_reg <= S_IDLE;
                end
                // close: extents and area check, then means and the result if both limits pass
                S_C_EXT:
                begin
                    ex_reg    <= ex_c;
                    ey_reg    <= ey_c;
                    state_reg <= S_C_CHK;
                end
                S_C_CHK:
                begin
                    coord_reg <= '0;
                    state_reg <= close_fail ? S_C_DONE : S_DIV_LD;
                end
                S_DIV_LD:
                begin
                    div_neg_reg <= sum_sel[SUM_W-1];
                    div_q_reg   <= sum_sel[SUM_W-1] ? (~sum_sel + 1'b1) : sum_sel;
                    div_r_reg   <= '0;
                    div_cnt_reg <= DCNT_W'(SUM_W);
                    state_reg   <= S_DIV_RUN;
                end
                S_DIV_RUN:
                begin
                    div_r_reg   <= rem_ge ? CNT_W'(rem_t - {1'b0, count_reg})
                                          : rem_t[CNT_W-1:0];
                    div_q_reg   <= {div_q_reg[SUM_W-2:0], rem_ge};
                    div_cnt_reg <= div_cnt_reg - 1'b1;
                    if (div_cnt_reg == DCNT_W'(1))
                        state_reg <= S_DIV_ST;
                end
                S_DIV_ST:
                begin
                    case (coord_reg)
                        2'd0:    mean_x_reg <= q_signed[31:0];
                        2'd1:    mean_y_reg <= q_signed[31:0];
                        default: mean_z_reg <= q_signed[31:0];
                    endcase
                    coord_reg <= coord_reg + 1'b1;
                    state_reg <= (coord_reg == 2'd2) ? S_EMIT : S_DIV_LD;
                end
                S_EMIT:
                begin
                    // wait for a free output register
                    if (!out_valid_reg || out_ch.ready)
                    begin
                        out_valid_reg         <= 1'b1;
                        out_reg.cluster_label <= label_reg;
                        out_reg.point_count   <= count_reg;
                        out_reg.extent_x      <= ex_reg[7:0];
                        out_reg.extent_y      <= ey_reg[7:0];
                        out_reg.mean_x        <= mean_x_reg;
                        out_reg.mean_y        <= mean_y_reg;
                        out_reg.mean_z        <= mean_z_reg;
                        // a split close is final unless the last point's own cluster follows
                        out_reg.last_of_run   <= phase_last_reg ||
                                                 !(item_reg.last_point && single_pass);
                        state_reg             <= S_C_DONE;
                    end
                end
                S_C_DONE:
                begin
                    if (phase_last_reg)
                    begin
                        count_reg <= '0;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        // split: the point opens the next cluster
                        if (label_reg < LABEL_MAX)
                            label_reg <= label_reg + 1'b1;
                        count_reg  <= CNT_W'(1);
                        min_x_reg  <= item_reg.cell_x;
                        max_x_reg  <= item_reg.cell_x;
                        min_y_reg  <= item_reg.cell_y;
                        max_y_reg  <= item_reg.cell_y;
                        sum_x_reg  <= SUM_W'(item_reg.pos_x);
                        sum_y_reg  <= SUM_W'(item_reg.pos_y);
                        sum_z_reg  <= SUM_W'(item_reg.pos_z);
                        prev_x_reg <= item_reg.pos_x;
                        prev_y_reg <= item_reg.pos_y;
                        state_reg  <= S_LASTCHK;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: hdl/lsgc_checker.sv
// checker: port-level assertions for the gap clustering block, with its bind
`default_nettype none
module lsgc_checker (
    input wire                      clk,
    input wire                      rst_n,
    input wire                      in_valid,
    input wire                      in_ready,
    input wire                      out_valid,
    input wire                      out_ready,
    input wire lsgc_pkg::out_item_t out_data
);
    import lsgc_pkg::*;

    // stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_data))
        else $error("stalled result changed");

    // one point at a time: busy right after a request
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while busy");

    a_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.point_count != '0) && (out_data.extent_x != '0) &&
                      (out_data.extent_y != '0) && (out_data.cluster_label != '0))
        else $error("result with empty cluster fields");

endmodule

bind laser_scan_gap_clustering lsgc_checker u_lsgc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data)
);
`default_nettype wire
